FILE: rtl/pla_pkg.sv
// Package for the sum-of-products logic array evaluator.
// Field widths, opcodes, register indexes, reset values and shared structs.
// No dependencies.
package pla_pkg;

    localparam int OP_W     = 2;
    localparam int ROW_W    = 4;
    localparam int FUSE_W   = 16;
    localparam int VEC_W    = 8;
    localparam int OIDX_W   = 4;

    localparam int N_IN_W   = 4;
    localparam int N_OUT_W  = 4;
    localparam int N_PR_W   = 5;
    localparam int CFG_W    = 5;
    localparam int CFG_IDX_W = 2;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 8;

    localparam logic [N_IN_W-1:0]  N_IN_RST  = 4'd8;
    localparam logic [N_OUT_W-1:0] N_OUT_RST = 4'd8;
    localparam logic [N_PR_W-1:0]  N_PR_RST  = 5'd16;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_AND = 2'd0,
        OP_LOAD_OR  = 2'd1,
        OP_EVAL     = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INPUTS   = 2'd0,
        CFG_OUTPUTS  = 2'd1,
        CFG_PRODUCTS = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ROW_W-1:0]  row_index;
        logic [FUSE_W-1:0] fuse_word;
        logic [VEC_W-1:0]  input_values;
        logic [OIDX_W-1:0] output_index;
    } t_item;

    typedef struct packed {
        logic [N_IN_W-1:0]  inputs_in_use;
        logic [N_OUT_W-1:0] outputs_in_use;
        logic [N_PR_W-1:0]  products_in_use;
    } t_cfg;

    typedef struct packed {
        logic and_we;
        logic or_we;
    } t_plane_wr;

endpackage

FILE: rtl/pla_planes.sv
// AND and OR plane storage of the logic array, cleared at reset.
// Depends on pla_pkg.
module pla_planes #(
    parameter int MAX_INPUTS   = 8,
    parameter int MAX_PRODUCTS = 16,
    parameter int MAX_OUTPUTS  = 8
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  pla_pkg::t_plane_wr                            i_wr,
    input  pla_pkg::t_item                                i_item,
    output logic [MAX_PRODUCTS-1:0][2*MAX_INPUTS-1:0]     o_and_plane,
    output logic [MAX_OUTPUTS-1:0][MAX_PRODUCTS-1:0]      o_or_plane
);

    localparam int AND_W = 2 * MAX_INPUTS;
    localparam int AEXT_W = (AND_W > pla_pkg::FUSE_W) ? AND_W : pla_pkg::FUSE_W;
    localparam int OEXT_W = (MAX_PRODUCTS > pla_pkg::FUSE_W) ? MAX_PRODUCTS
                                                             : pla_pkg::FUSE_W;

    logic [MAX_PRODUCTS-1:0][AND_W-1:0]        r_and, n_and;
    logic [MAX_OUTPUTS-1:0][MAX_PRODUCTS-1:0]  r_or, n_or;
    logic [AEXT_W-1:0] and_ext;
    logic [OEXT_W-1:0] or_ext;

    // Fuse bits past the row width drop, missing ones read as zero.
    assign and_ext = AEXT_W'(i_item.fuse_word);
    assign or_ext  = OEXT_W'(i_item.fuse_word);

    always_comb begin
        n_and = r_and;
        n_or  = r_or;
        for (int p = 0; p < MAX_PRODUCTS; p++) begin
            if (i_wr.and_we && (int'(i_item.row_index) == p)) begin
                n_and[p] = and_ext[AND_W-1:0];
            end
        end
        for (int o = 0; o < MAX_OUTPUTS; o++) begin
            if (i_wr.or_we && (int'(i_item.row_index) == o)) begin
                n_or[o] = or_ext[MAX_PRODUCTS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_and <= '0;
            r_or  <= '0;
        end else begin
            r_and <= n_and;
            r_or  <= n_or;
        end
    end

    assign o_and_plane = r_and;
    assign o_or_plane  = r_or;

endmodule

FILE: rtl/pla_eval.sv
// Combinational sum-of-products evaluation of one output for one input vector.
// Depends on pla_pkg.
module pla_eval #(
    parameter int MAX_INPUTS   = 8,
    parameter int MAX_PRODUCTS = 16,
    parameter int MAX_OUTPUTS  = 8
) (
    input  pla_pkg::t_item                                i_item,
    input  pla_pkg::t_cfg                                 i_cfg,
    input  logic [MAX_PRODUCTS-1:0][2*MAX_INPUTS-1:0]     i_and_plane,
    input  logic [MAX_OUTPUTS-1:0][MAX_PRODUCTS-1:0]      i_or_plane,
    output logic                                          o_out_value,
    output logic                                          o_index_error
);

    localparam int VEXT_W = (MAX_INPUTS > pla_pkg::VEC_W) ? MAX_INPUTS : pla_pkg::VEC_W;

    logic [VEXT_W-1:0]       vec_ext;
    logic [MAX_PRODUCTS-1:0] prod;
    logic [MAX_PRODUCTS-1:0] or_row;

    // Inputs past the vector width read as zero.
    assign vec_ext = VEXT_W'(i_item.input_values);

    always_comb begin
        logic all_ok;
        logic any_fuse;
        logic inv;
        logic rg;
        logic v;
        logic used;
        for (int p = 0; p < MAX_PRODUCTS; p++) begin
            all_ok   = 1'b1;
            any_fuse = 1'b0;
            for (int j = 0; j < MAX_INPUTS; j++) begin
                inv  = i_and_plane[p][2*j];
                rg   = i_and_plane[p][2*j+1];
                v    = vec_ext[j];
                used = (int'(i_cfg.inputs_in_use) > j);
                if (used) begin
                    all_ok   = all_ok & ((v & ~inv) | (~v & ~rg));
                    any_fuse = any_fuse | inv | rg;
                end
            end
            // all-zero fuse row means inactive term
            prod[p] = all_ok & any_fuse & (int'(i_cfg.products_in_use) > p);
        end
    end

    always_comb begin
        or_row = '0;
        for (int o = 0; o < MAX_OUTPUTS; o++) begin
            if (int'(i_item.output_index) == o) begin
                or_row = i_or_plane[o];
            end
        end
    end

    assign o_index_error = (int'(i_item.output_index) >= int'(i_cfg.outputs_in_use))
                        || (int'(i_item.output_index) >= MAX_OUTPUTS);
    assign o_out_value   = ~o_index_error & (|(or_row & prod));

endmodule

FILE: rtl/pla_sum_of_products_eval_unit.sv
// Top level of the sum-of-products logic array evaluator (stream in/out).
// Depends on pla_pkg, pla_planes and pla_eval.
// An accepted evaluate goes through the input register, then the result register;
//   throughput is one transaction per cycle while the result stream does not stall.
// Loads take effect for any evaluate accepted in the following cycle or later.
// Reset (i_rst_n low, synchronous) clears both planes, empties the pipeline and
//   returns the config registers to 8 inputs, 8 outputs, 16 products.
module pla_sum_of_products_eval_unit #(
    parameter int MAX_INPUTS   = 8,
    parameter int MAX_PRODUCTS = 16,
    parameter int MAX_OUTPUTS  = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // config write port
    input  logic                             i_cfg_we,
    input  logic [pla_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pla_pkg::CFG_W-1:0]        i_cfg_wdata,
    // input stream
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // tdata: row_index[3:0], fuse_word[19:4], input_values[27:20], output_index[31:28]
    input  logic [pla_pkg::S_TDATA_W-1:0]    i_s_axis_tdata,
    // tuser: op[1:0]
    input  logic [pla_pkg::OP_W-1:0]         i_s_axis_tuser,
    // result stream
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // tdata: out_value[0], index_error[1], zero pad[7:2]
    output logic [pla_pkg::M_TDATA_W-1:0]    o_m_axis_tdata
);

    logic [MAX_PRODUCTS-1:0][2*MAX_INPUTS-1:0] and_plane;
    logic [MAX_OUTPUTS-1:0][MAX_PRODUCTS-1:0]  or_plane;

    pla_pkg::t_cfg     r_cfg;
    pla_pkg::t_item    r_item, in_item;
    logic              r_s1_valid;
    logic              r_out_valid;
    logic              r_out_value;
    logic              r_out_err;
    logic              s1_is_eval;
    logic              out_stall;
    logic              s1_adv;
    logic              in_take;
    logic              eval_value;
    logic              eval_err;
    pla_pkg::t_plane_wr plane_wr;

    // Unpack stream payload
    assign in_item.op           = i_s_axis_tuser;
    assign in_item.row_index    = i_s_axis_tdata[3:0];
    assign in_item.fuse_word    = i_s_axis_tdata[19:4];
    assign in_item.input_values = i_s_axis_tdata[27:20];
    assign in_item.output_index = i_s_axis_tdata[31:28];

    // Config registers; unknown index ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.inputs_in_use   <= pla_pkg::N_IN_RST;
            r_cfg.outputs_in_use  <= pla_pkg::N_OUT_RST;
            r_cfg.products_in_use <= pla_pkg::N_PR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pla_pkg::CFG_INPUTS:
                    r_cfg.inputs_in_use <= i_cfg_wdata[pla_pkg::N_IN_W-1:0];
                pla_pkg::CFG_OUTPUTS:
                    r_cfg.outputs_in_use <= i_cfg_wdata[pla_pkg::N_OUT_W-1:0];
                pla_pkg::CFG_PRODUCTS:
                    r_cfg.products_in_use <= i_cfg_wdata[pla_pkg::N_PR_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline control: loads always leave stage 1, evaluates need a free result slot.
    assign s1_is_eval      = (r_item.op == pla_pkg::OP_EVAL);
    assign out_stall       = r_out_valid && !i_m_axis_tready;
    assign s1_adv          = r_s1_valid && (!s1_is_eval || !out_stall);
    assign o_s_axis_tready = !r_s1_valid || s1_adv;
    assign in_take         = i_s_axis_tvalid && o_s_axis_tready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_s1_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item <= in_item;
        end
    end

    // Plane writes come from stage 1, so a following evaluate sees them.
    assign plane_wr.and_we = s1_adv && (r_item.op == pla_pkg::OP_LOAD_AND);
    assign plane_wr.or_we  = s1_adv && (r_item.op == pla_pkg::OP_LOAD_OR);

    pla_planes #(
        .MAX_INPUTS   (MAX_INPUTS),
        .MAX_PRODUCTS (MAX_PRODUCTS),
        .MAX_OUTPUTS  (MAX_OUTPUTS)
    ) u_planes (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (plane_wr),
        .i_item      (r_item),
        .o_and_plane (and_plane),
        .o_or_plane  (or_plane)
    );

    pla_eval #(
        .MAX_INPUTS   (MAX_INPUTS),
        .MAX_PRODUCTS (MAX_PRODUCTS),
        .MAX_OUTPUTS  (MAX_OUTPUTS)
    ) u_eval (
        .i_item        (r_item),
        .i_cfg         (r_cfg),
        .i_and_plane   (and_plane),
        .i_or_plane    (or_plane),
        .o_out_value   (eval_value),
        .o_index_error (eval_err)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && s1_is_eval) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && s1_is_eval) begin
            r_out_value <= eval_value;
            r_out_err   <= eval_err;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'b0, r_out_err, r_out_value};

`ifndef SYNTH
    // An error result always carries a zero value.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_value && r_out_err))
        else $error("error result with nonzero value");

    // An evaluate leaving stage 1 yields a result next cycle.
    a_eval_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && s1_is_eval) |=> r_out_valid)
        else $error("evaluate lost");

    // Loads and ignored ops never create a result.
    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!(r_s1_valid && s1_is_eval) && !out_stall) |=> !r_out_valid)
        else $error("result without evaluate");

    // Stage 1 holds an evaluate while the result slot is stalled.
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && s1_is_eval && out_stall) |=> (r_s1_valid && $stable(r_item)))
        else $error("stage 1 dropped a stalled evaluate");
`endif

endmodule

FILE: test/testbench.sv
// Self-checking testbench for pla_sum_of_products_eval_unit.
// A stream driver, a result monitor and a sum-of-products predictor check every evaluation.
// Depends on pla_pkg and the RTL of the block.
`timescale 1ns / 1ps

module testbench;

    localparam int MAX_INPUTS   = 8;
    localparam int MAX_PRODUCTS = 16;
    localparam int MAX_OUTPUTS  = 8;

    // tuser code that the block must drop without a result
    localparam logic [pla_pkg::OP_W-1:0] OP_RESERVED = 2'd3;

    // cycles with no transaction on either side before the run is called hung
    localparam int STALL_LIMIT = 2000;
    // two-stage pipeline, plus margin
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 8;

    localparam int PHASES = 9;

    // result word as it sits in the low bits of o_m_axis_tdata
    typedef struct packed {
        logic index_error;
        logic out_value;
    } t_eval_result;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_we = 1'b0;
    logic [pla_pkg::CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [pla_pkg::CFG_W-1:0]       i_cfg_wdata = '0;
    logic                            i_s_axis_tvalid = 1'b0;
    logic                            o_s_axis_tready;
    logic [pla_pkg::S_TDATA_W-1:0]   i_s_axis_tdata = '0;
    logic [pla_pkg::OP_W-1:0]        i_s_axis_tuser = '0;
    logic                            o_m_axis_tvalid;
    logic                            i_m_axis_tready = 1'b0;
    logic [pla_pkg::M_TDATA_W-1:0]   o_m_axis_tdata;

    // Per-phase register values; some exceed the maximum, some are zero,
    // two have bit 4 set on a 4-bit register (31 -> 15, 23 -> 7).
    logic [pla_pkg::CFG_W-1:0] phase_inputs   [PHASES] = '{5'd8, 5'd31, 5'd3, 5'd1, 5'd0,
                                                           5'd8, 5'd8, 5'd23, 5'd8};
    logic [pla_pkg::CFG_W-1:0] phase_outputs  [PHASES] = '{5'd8, 5'd15, 5'd5, 5'd1, 5'd8,
                                                           5'd0, 5'd8, 5'd6, 5'd8};
    logic [pla_pkg::CFG_W-1:0] phase_products [PHASES] = '{5'd16, 5'd31, 5'd7, 5'd1, 5'd16,
                                                           5'd16, 5'd0, 5'd12, 5'd16};
    int               phase_items    [PHASES] = '{100, 80, 60, 50, 30, 30, 30, 120, 130};

    // predictor copy of the array and its registers
    logic [pla_pkg::FUSE_W-1:0]  and_rows [MAX_PRODUCTS];
    logic [pla_pkg::FUSE_W-1:0]  or_rows  [MAX_OUTPUTS];
    logic [pla_pkg::N_IN_W-1:0]  cfg_inputs   = pla_pkg::N_IN_RST;
    logic [pla_pkg::N_OUT_W-1:0] cfg_outputs  = pla_pkg::N_OUT_RST;
    logic [pla_pkg::N_PR_W-1:0]  cfg_products = pla_pkg::N_PR_RST;

    pla_pkg::t_item pending_items[$];
    t_eval_result   eval_results_due[$];

    pla_pkg::t_item next_item;
    pla_pkg::t_item seen_item;
    t_eval_result   want;
    logic           in_taken = 1'b0;
    int             quiet_cycles = 0;
    int             fail_count = 0;
    int             send_idle_pct = 0;
    int             recv_stall_pct = 0;

    pla_sum_of_products_eval_unit #(
        .MAX_INPUTS   (MAX_INPUTS),
        .MAX_PRODUCTS (MAX_PRODUCTS),
        .MAX_OUTPUTS  (MAX_OUTPUTS)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        // tdata: row_index[3:0], fuse_word[19:4], input_values[27:20], output_index[31:28]
        .i_s_axis_tdata  (i_s_axis_tdata),
        // tuser: op[1:0]
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        // tdata: out_value[0], index_error[1], zero pad[7:2]
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // One product term: AND of the literals over the examined inputs.
    // Fuse pair {reg, inv}: 00 don't care, 10 true, 01 complemented, 11 forced zero.
    // A term with no fuse blown among the examined inputs is inactive.
    function automatic logic product_term(input logic [pla_pkg::FUSE_W-1:0] fuses,
                                          input logic [pla_pkg::VEC_W-1:0] vec,
                                          input int n_in);
        logic all_lit;
        logic any_fuse;
        logic inv;
        logic rg;
        logic v;
        all_lit  = 1'b1;
        any_fuse = 1'b0;
        for (int j = 0; j < n_in; j++) begin
            inv = fuses[2*j];
            rg  = fuses[2*j+1];
            v   = vec[j];
            all_lit  &= (v & ~inv) | (~v & ~rg);
            any_fuse |= inv | rg;
        end
        return all_lit & any_fuse;
    endfunction

    // Apply one accepted transaction to the array copy; evaluations queue a result.
    function automatic void predict_transaction(input pla_pkg::t_item it);
        int           n_in;
        int           n_out;
        int           n_pr;
        t_eval_result r;
        // registers above the array size saturate
        n_in  = (cfg_inputs   > MAX_INPUTS)   ? MAX_INPUTS   : cfg_inputs;
        n_out = (cfg_outputs  > MAX_OUTPUTS)  ? MAX_OUTPUTS  : cfg_outputs;
        n_pr  = (cfg_products > MAX_PRODUCTS) ? MAX_PRODUCTS : cfg_products;
        case (it.op)
            pla_pkg::OP_LOAD_AND: begin
                and_rows[it.row_index] = it.fuse_word;
            end
            pla_pkg::OP_LOAD_OR: begin
                // rows past the OR plane are dropped
                if (it.row_index < MAX_OUTPUTS) begin
                    or_rows[it.row_index] = it.fuse_word;
                end
            end
            pla_pkg::OP_EVAL: begin
                r = '0;
                if (it.output_index >= n_out) begin
                    r.index_error = 1'b1;
                end else begin
                    for (int p = 0; p < n_pr; p++) begin
                        if (or_rows[it.output_index][p]) begin
                            r.out_value |= product_term(and_rows[p], it.input_values, n_in);
                        end
                    end
                end
                eval_results_due = {eval_results_due, r};
            end
            default: begin
                // reserved code: no state change, no result
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic queue_item(input logic [pla_pkg::OP_W-1:0] op,
                              input logic [pla_pkg::ROW_W-1:0] row,
                              input logic [pla_pkg::FUSE_W-1:0] fuse,
                              input logic [pla_pkg::VEC_W-1:0] vec,
                              input logic [pla_pkg::OIDX_W-1:0] oidx);
        pla_pkg::t_item it;
        it.op           = op;
        it.row_index    = row;
        it.fuse_word    = fuse;
        it.input_values = vec;
        it.output_index = oidx;
        pending_items = {pending_items, it};
    endtask

    // Register write while the block is idle; the predictor copy follows at once.
    task automatic write_reg(input pla_pkg::t_cfg_idx idx,
                             input logic [pla_pkg::CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        case (idx)
            pla_pkg::CFG_INPUTS:   cfg_inputs   = val[pla_pkg::N_IN_W-1:0];
            pla_pkg::CFG_OUTPUTS:  cfg_outputs  = val[pla_pkg::N_OUT_W-1:0];
            pla_pkg::CFG_PRODUCTS: cfg_products = val[pla_pkg::N_PR_W-1:0];
            default:      ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Wait until every queued item went in and every result came out,
    // then let the pipeline settle (loads leave no result behind).
    task automatic drain(input int settle);
        while (pending_items.size() != 0 || i_s_axis_tvalid || eval_results_due.size() != 0)
            @(negedge i_clk);
        repeat (settle) @(negedge i_clk);
    endtask

    // Random transaction biased toward useful array contents:
    // AND rows mostly don't-care/literal pairs so product terms fire often.
    function automatic pla_pkg::t_item random_item();
        pla_pkg::t_item it;
        int    pick;
        int    n_out;
        n_out = (cfg_outputs > MAX_OUTPUTS) ? MAX_OUTPUTS : cfg_outputs;
        it.row_index    = pla_pkg::ROW_W'($urandom);
        it.fuse_word    = pla_pkg::FUSE_W'($urandom);
        it.input_values = pla_pkg::VEC_W'($urandom);
        it.output_index = pla_pkg::OIDX_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 22) begin
            it.op = pla_pkg::OP_LOAD_AND;
            if ($urandom_range(0, 9) != 0) begin
                for (int j = 0; j < MAX_INPUTS; j++) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 50)      it.fuse_word[2*j +: 2] = 2'b00;
                    else if (pick < 72) it.fuse_word[2*j +: 2] = 2'b10;
                    else if (pick < 94) it.fuse_word[2*j +: 2] = 2'b01;
                    else                it.fuse_word[2*j +: 2] = 2'b11;
                end
            end
        end else if (pick < 38) begin
            it.op = pla_pkg::OP_LOAD_OR;
            if ($urandom_range(0, 9) != 0)
                it.row_index = pla_pkg::ROW_W'($urandom_range(0, 7));
            if ($urandom_range(0, 1) != 0) it.fuse_word &= pla_pkg::FUSE_W'($urandom);
        end else if (pick < 95) begin
            it.op = pla_pkg::OP_EVAL;
            // mostly valid output indexes, some out of range
            if (n_out > 0 && $urandom_range(0, 99) < 85)
                it.output_index = pla_pkg::OIDX_W'($urandom_range(0, n_out - 1));
        end else begin
            it.op = OP_RESERVED;
        end
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Driver: input stream and result ready, both changed on the falling edge
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_s_axis_tvalid || in_taken)) begin
            if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                next_item = pending_items.pop_front();
                i_s_axis_tdata  <= {next_item.output_index, next_item.input_values,
                                    next_item.fuse_word, next_item.row_index};
                i_s_axis_tuser  <= next_item.op;
                i_s_axis_tvalid <= 1'b1;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
        i_m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // Monitor: both transactions sampled at the rising edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        in_taken <= i_s_axis_tvalid && o_s_axis_tready;
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (eval_results_due.size() == 0) begin
                    $error("result transaction with no evaluation outstanding: tdata %h",
                           o_m_axis_tdata);
                    fail_count++;
                end else begin
                    want = eval_results_due.pop_front();
                    if (o_m_axis_tdata[0] !== want.out_value) begin
                        $error("out_value: expected %0d, got %0d",
                               want.out_value, o_m_axis_tdata[0]);
                        fail_count++;
                    end
                    if (o_m_axis_tdata[1] !== want.index_error) begin
                        $error("index_error: expected %0d, got %0d",
                               want.index_error, o_m_axis_tdata[1]);
                        fail_count++;
                    end
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                seen_item.op           = i_s_axis_tuser;
                seen_item.row_index    = i_s_axis_tdata[3:0];
                seen_item.fuse_word    = i_s_axis_tdata[19:4];
                seen_item.input_values = i_s_axis_tdata[27:20];
                seen_item.output_index = i_s_axis_tdata[31:28];
                predict_transaction(seen_item);
            end
            if ((o_m_axis_tvalid && i_m_axis_tready) || (i_s_axis_tvalid && o_s_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // hang detection
    always @(posedge i_clk) begin
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        int             useful;
        pla_pkg::t_item it;
        foreach (and_rows[p]) and_rows[p] = '0;
        foreach (or_rows[o]) or_rows[o] = '0;

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // sender idles often, receiver stalls most of the time
        send_idle_pct  = 30;
        recv_stall_pct = 79;

        // Directed part, reset register values (8 inputs, 8 outputs, 16 products).
        // Planes start cleared: an evaluation before any load gives 0.
        queue_item(pla_pkg::OP_EVAL,     4'd0,  16'h0000, 8'hFF, 4'd0);
        queue_item(pla_pkg::OP_LOAD_AND, 4'd0,  16'h0002, 8'h00, 4'd0);  // product 0 = in0
        queue_item(pla_pkg::OP_LOAD_AND, 4'd1,  16'hAAAA, 8'h00, 4'd0);  // AND of all inputs
        queue_item(pla_pkg::OP_LOAD_AND, 4'd2,  16'h5555, 8'h00, 4'd0);  // NOR of all inputs
        queue_item(pla_pkg::OP_LOAD_AND, 4'd3,  16'hFFFF, 8'h00, 4'd0);  // forced zero
        queue_item(pla_pkg::OP_LOAD_AND, 4'd15, 16'h0001, 8'h00, 4'd0);  // last product = ~in0
        queue_item(pla_pkg::OP_LOAD_OR,  4'd0,  16'h0006, 8'h00, 4'd0);
        queue_item(pla_pkg::OP_LOAD_OR,  4'd7,  16'hFFFF, 8'h00, 4'd0);
        queue_item(pla_pkg::OP_LOAD_OR,  4'd8,  16'hFFFF, 8'h00, 4'd0);  // past the OR plane
        queue_item(pla_pkg::OP_LOAD_OR,  4'd1,  16'h8001, 8'h00, 4'd0);
        queue_item(pla_pkg::OP_EVAL,     4'd0,  16'h0000, 8'hFF, 4'd0);
        queue_item(pla_pkg::OP_EVAL,     4'd0,  16'h0000, 8'h00, 4'd0);
        queue_item(pla_pkg::OP_EVAL,     4'd0,  16'h0000, 8'h5A, 4'd0);
        queue_item(pla_pkg::OP_EVAL,     4'd0,  16'h0000, 8'hFE, 4'd7);
        queue_item(pla_pkg::OP_EVAL,     4'd0,  16'h0000, 8'h00, 4'd1);
        queue_item(pla_pkg::OP_EVAL,     4'd0,  16'h0000, 8'h01, 4'd1);
        queue_item(pla_pkg::OP_EVAL,     4'd0,  16'h0000, 8'hFF, 4'd2);
        queue_item(pla_pkg::OP_EVAL,     4'd0,  16'h0000, 8'h00, 4'd8);  // index error
        queue_item(pla_pkg::OP_EVAL,     4'hF,  16'hFFFF, 8'hFF, 4'd15); // index error
        queue_item(OP_RESERVED,          4'hF,  16'hFFFF, 8'hFF, 4'hF);  // dropped
        queue_item(pla_pkg::OP_LOAD_AND, 4'd0,  16'h0000, 8'h00, 4'd0);  // product 0 inactive
        queue_item(pla_pkg::OP_EVAL,     4'd0,  16'h0000, 8'h01, 4'd1);
        queue_item(pla_pkg::OP_EVAL,     4'd0,  16'h0000, 8'h80, 4'd1);
        queue_item(pla_pkg::OP_LOAD_OR,  4'd7,  16'h0000, 8'h00, 4'd0);
        queue_item(pla_pkg::OP_EVAL,     4'd0,  16'h0000, 8'hAB, 4'd7);
        drain(SETTLE_CYCLES);

        // Random phases, each under its own register setting.
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph == 3) begin
                send_idle_pct  = 79;
                recv_stall_pct = 30;
            end else if (ph == 6) begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            write_reg(pla_pkg::CFG_INPUTS,   phase_inputs[ph]);
            write_reg(pla_pkg::CFG_OUTPUTS,  phase_outputs[ph]);
            write_reg(pla_pkg::CFG_PRODUCTS, phase_products[ph]);
            // dropped transactions (reserved code, OR row past the plane) not counted
            useful = 0;
            while (useful < phase_items[ph]) begin
                it = random_item();
                pending_items = {pending_items, it};
                if (!(it.op == OP_RESERVED ||
                      (it.op == pla_pkg::OP_LOAD_OR && it.row_index >= MAX_OUTPUTS)))
                    useful++;
            end
            drain(SETTLE_CYCLES);
        end

        drain(DRAIN_CYCLES);
        if (fail_count == 0 && eval_results_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/pla_pkg.sv
rtl/pla_planes.sv
rtl/pla_eval.sv
rtl/pla_sum_of_products_eval_unit.sv
test/testbench.sv
